>>> rtl/core/hfr_pkg.sv
// Shared types and constants for the HART frame receiver.
// Used by hfr_framer, hfr_rsp_buf and hart_frame_receiver; depends on nothing.

package hfr_pkg;

   // Receive phases, in the order reported on rx_phase.
   typedef enum logic [3:0] {
      PH_HUNT       = 4'd0,
      PH_PREAMBLE   = 4'd1,
      PH_DELIM      = 4'd2,
      PH_LONG_ADDR  = 4'd3,
      PH_SHORT_ADDR = 4'd4,
      PH_COMMAND    = 4'd5,
      PH_COUNT      = 4'd6,
      PH_DATA       = 4'd7,
      PH_CHECK      = 4'd8
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       frame_done;
      logic       frame_aborted;
      logic [4:0] comm_errors;
      logic [8:0] frame_length;
      logic [7:0] delimiter_byte;
      logic [7:0] first_address_byte;
      phase_type  rx_phase;
   } rsp_type;

   // Message buffer size in bytes; positions at or above it are not stored.
   localparam int BUFFER_BYTES = 256;

   localparam logic [7:0] PREAMBLE_BYTE  = 8'hFF;
   localparam logic [7:0] EXPANSION_MASK = 8'h60;

   // Frame types accepted in the low three delimiter bits.
   localparam logic [2:0] FTYPE_BACK = 3'd1;
   localparam logic [2:0] FTYPE_STX  = 3'd2;
   localparam logic [2:0] FTYPE_ACK  = 3'd6;

   // Position one past the address field for each address form.
   localparam logic [8:0] LONG_ADDR_END  = 9'd6;
   localparam logic [8:0] SHORT_ADDR_END = 9'd2;

   // Communication error flag masks.
   localparam logic [4:0] ERR_OVERFLOW = 5'b01000;
   localparam logic [4:0] ERR_CHECK    = 5'b10000;

   // Operation codes on the input tuser bit: received byte or release.
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Configuration register index and reset value.
   localparam logic           REG_GAP_LIMIT   = 1'b0;
   localparam logic [15:0]    GAP_LIMIT_RESET = 16'd20;

endpackage

>>> rtl/core/hfr_framer.sv
// Framing state machine and datapath of the HART frame receiver.
// Computes the result of one beat and updates the framing state when it is accepted.
// Depends on hfr_pkg.

module hfr_framer (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic             op,
   input  logic [7:0]       rx_byte,
   input  logic [2:0]       uart_err,
   input  logic [15:0]      tick,
   input  logic [15:0]      gap_limit,
   output hfr_pkg::rsp_type result
);

   hfr_pkg::phase_type phase_ff, phase_in;
   logic [8:0]  write_index_ff, write_index_in;
   logic [8:0]  field_end_ff, field_end_in;
   logic [15:0] last_tick_ff, last_tick_in;
   logic [7:0]  check_ff, check_in;
   logic [4:0]  errors_ff, errors_in;
   logic [7:0]  delim_ff, delim_in;
   logic [7:0]  addr_ff, addr_in;
   logic        pending_ff, pending_in;

   logic [15:0] tick_dist;
   logic        gap_hit;
   logic        uerr_any;
   logic        is_ff;
   logic        delim_ok;
   logic [8:0]  index_next;
   logic        overflow;
   logic        byte_step;
   logic [7:0]  check_xor;

   logic        st_valid;
   logic [7:0]  st_index;
   logic        done;
   logic        abort;
   logic        go_hunt;

   assign tick_dist  = tick - last_tick_ff;
   assign gap_hit    = tick_dist > gap_limit;
   assign uerr_any   = |uart_err;
   assign is_ff      = rx_byte == hfr_pkg::PREAMBLE_BYTE;
   assign delim_ok   = ((rx_byte & hfr_pkg::EXPANSION_MASK) == 8'h00) &&
                       ((rx_byte[2:0] == hfr_pkg::FTYPE_BACK) ||
                        (rx_byte[2:0] == hfr_pkg::FTYPE_STX) ||
                        (rx_byte[2:0] == hfr_pkg::FTYPE_ACK));
   assign index_next = write_index_ff + 9'd1;
   assign overflow   = write_index_ff >= 9'(hfr_pkg::BUFFER_BYTES);
   assign byte_step  = (op == hfr_pkg::OP_BYTE) && !pending_ff;
   assign check_xor  = check_ff ^ rx_byte;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (op == hfr_pkg::OP_RELEASE) begin
         phase_in = hfr_pkg::PH_HUNT;
      end else if (!pending_ff) begin
         case (phase_ff)
            hfr_pkg::PH_HUNT: begin
               if (!uerr_any && is_ff) phase_in = hfr_pkg::PH_PREAMBLE;
            end
            hfr_pkg::PH_PREAMBLE: begin
               if (!gap_hit && !uerr_any && is_ff) phase_in = hfr_pkg::PH_DELIM;
               else phase_in = hfr_pkg::PH_HUNT;
            end
            hfr_pkg::PH_DELIM: begin
               if (gap_hit || uerr_any) phase_in = hfr_pkg::PH_HUNT;
               else if (!is_ff) begin
                  if (!delim_ok) phase_in = hfr_pkg::PH_HUNT;
                  else if (rx_byte[7]) phase_in = hfr_pkg::PH_LONG_ADDR;
                  else phase_in = hfr_pkg::PH_SHORT_ADDR;
               end
            end
            hfr_pkg::PH_LONG_ADDR, hfr_pkg::PH_SHORT_ADDR: begin
               if (gap_hit || uerr_any) phase_in = hfr_pkg::PH_HUNT;
               else if (index_next == field_end_ff) phase_in = hfr_pkg::PH_COMMAND;
            end
            hfr_pkg::PH_COMMAND: begin
               if (gap_hit) phase_in = hfr_pkg::PH_HUNT;
               else phase_in = hfr_pkg::PH_COUNT;
            end
            hfr_pkg::PH_COUNT: begin
               if (gap_hit || uerr_any) phase_in = hfr_pkg::PH_HUNT;
               else if (rx_byte != 8'h00) phase_in = hfr_pkg::PH_DATA;
               else phase_in = hfr_pkg::PH_CHECK;
            end
            hfr_pkg::PH_DATA: begin
               if (gap_hit) phase_in = hfr_pkg::PH_HUNT;
               else if (index_next == field_end_ff) phase_in = hfr_pkg::PH_CHECK;
            end
            hfr_pkg::PH_CHECK: begin
               if (gap_hit) phase_in = hfr_pkg::PH_HUNT;
            end
            default: begin
               phase_in = hfr_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // Datapath and beat outputs.
   always_comb begin
      write_index_in = write_index_ff;
      field_end_in   = field_end_ff;
      last_tick_in   = last_tick_ff;
      check_in       = check_ff;
      errors_in      = errors_ff;
      delim_in       = delim_ff;
      addr_in        = addr_ff;
      pending_in     = pending_ff;
      st_valid       = 1'b0;
      st_index       = write_index_ff[7:0];
      done           = 1'b0;
      abort          = 1'b0;
      go_hunt        = (op == hfr_pkg::OP_RELEASE);
      if (byte_step) begin
         // Every phase past hunt restarts the gap timer on each byte.
         if (phase_ff != hfr_pkg::PH_HUNT) last_tick_in = tick;
         case (phase_ff)
            hfr_pkg::PH_HUNT: begin
               if (!uerr_any && is_ff) last_tick_in = tick;
            end
            hfr_pkg::PH_PREAMBLE: begin
               if (gap_hit || uerr_any || !is_ff) abort = 1'b1;
            end
            hfr_pkg::PH_DELIM: begin
               if (gap_hit || uerr_any) begin
                  abort = 1'b1;
               end else if (!is_ff) begin
                  if (!delim_ok) begin
                     abort = 1'b1;
                  end else begin
                     errors_in      = 5'd0;
                     delim_in       = rx_byte;
                     addr_in        = 8'h00;
                     check_in       = rx_byte;
                     st_valid       = 1'b1;
                     st_index       = 8'd0;
                     write_index_in = 9'd1;
                     field_end_in   = rx_byte[7] ? hfr_pkg::LONG_ADDR_END
                                                 : hfr_pkg::SHORT_ADDR_END;
                  end
               end
            end
            hfr_pkg::PH_LONG_ADDR, hfr_pkg::PH_SHORT_ADDR: begin
               if (gap_hit || uerr_any) begin
                  abort = 1'b1;
               end else begin
                  if (write_index_ff == 9'd1) addr_in = rx_byte;
                  st_valid       = 1'b1;
                  check_in       = check_xor;
                  write_index_in = index_next;
               end
            end
            hfr_pkg::PH_COMMAND: begin
               if (gap_hit) begin
                  abort = 1'b1;
               end else begin
                  errors_in      = errors_ff | {2'b00, uart_err};
                  st_valid       = 1'b1;
                  check_in       = check_xor;
                  write_index_in = index_next;
               end
            end
            hfr_pkg::PH_COUNT: begin
               if (gap_hit || uerr_any) begin
                  abort = 1'b1;
               end else begin
                  st_valid       = 1'b1;
                  check_in       = check_xor;
                  write_index_in = index_next;
                  if (rx_byte != 8'h00) field_end_in = index_next + {1'b0, rx_byte};
               end
            end
            hfr_pkg::PH_DATA: begin
               if (gap_hit) begin
                  abort = 1'b1;
               end else begin
                  errors_in      = errors_ff | {2'b00, uart_err} |
                                   (overflow ? hfr_pkg::ERR_OVERFLOW : 5'd0);
                  st_valid       = !overflow;
                  check_in       = check_xor;
                  write_index_in = index_next;
               end
            end
            hfr_pkg::PH_CHECK: begin
               if (gap_hit) begin
                  abort = 1'b1;
               end else begin
                  errors_in  = errors_ff | {2'b00, uart_err} |
                               (overflow ? hfr_pkg::ERR_OVERFLOW : 5'd0) |
                               ((check_xor != 8'h00) ? hfr_pkg::ERR_CHECK : 5'd0);
                  st_valid   = !overflow;
                  check_in   = check_xor;
                  pending_in = 1'b1;
                  done       = 1'b1;
               end
            end
            default: begin
               go_hunt = 1'b1;
            end
         endcase
      end
      if (go_hunt || abort) begin
         errors_in  = 5'd0;
         delim_in   = 8'h00;
         addr_in    = 8'h00;
         pending_in = 1'b0;
      end
   end

   always_comb begin
      result.store_valid        = st_valid;
      result.store_index        = st_valid ? st_index : 8'd0;
      result.store_byte         = st_valid ? rx_byte : 8'd0;
      result.frame_done         = done;
      result.frame_aborted      = abort;
      result.comm_errors        = errors_in;
      result.frame_length       = !done ? 9'd0 :
                                  (overflow ? 9'(hfr_pkg::BUFFER_BYTES) : write_index_ff);
      result.delimiter_byte     = done ? delim_ff : 8'h00;
      result.first_address_byte = done ? addr_ff : 8'h00;
      result.rx_phase           = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= hfr_pkg::PH_HUNT;
         write_index_ff <= 9'd0;
         field_end_ff   <= 9'd0;
         last_tick_ff   <= 16'd0;
         check_ff       <= 8'h00;
         errors_ff      <= 5'd0;
         delim_ff       <= 8'h00;
         addr_ff        <= 8'h00;
         pending_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         write_index_ff <= write_index_in;
         field_end_ff   <= field_end_in;
         last_tick_ff   <= last_tick_in;
         check_ff       <= check_in;
         errors_ff      <= errors_in;
         delim_ff       <= delim_in;
         addr_ff        <= addr_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

>>> rtl/core/hfr_rsp_buf.sv
// Two-entry result buffer: an output register plus a skid register.
// Keeps the input side accepting while one finished beat waits. Depends on hfr_pkg.

module hfr_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hfr_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output hfr_pkg::rsp_type out_data
);

   hfr_pkg::rsp_type head_ff, head_in;
   hfr_pkg::rsp_type skid_ff, skid_in;
   logic             head_valid_ff, head_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             push;
   logic             pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = head_valid_ff && out_ready;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff) begin
         if (push) begin
            head_in       = in_data;
            head_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            // No push is possible while the skid entry is full.
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            head_in = in_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/core/hart_frame_receiver.sv
// HART link layer frame receiver, top level: one result beat per accepted input beat.
// A result beat is registered in the output buffer before it appears on rsp_tvalid.
// Throughput: one input beat per cycle while the output buffer is not full; the
// two-entry output buffer keeps req_tready high while one result beat waits.
// Reset (synchronous, active high) returns to hunting, clears all framing state and
// empties the output buffer; the gap limit register returns to 20.
// Depends on hfr_pkg, hfr_framer and hfr_rsp_buf.

module hart_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: rx_byte[7:0], parity_error[8], overrun_error[9], framing_error[10],
   // tick[26:11], zero[31:27]
   input  logic [31:0] req_tdata,
   // tuser: op[0] (0 received byte, 1 release)
   input  logic        req_tuser,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: store_valid[0], store_index[8:1], store_byte[16:9], frame_done[17],
   // frame_aborted[18], comm_errors[23:19], frame_length[32:24],
   // delimiter_byte[40:33], first_address_byte[48:41], rx_phase[52:49], zero[55:53]
   output logic [55:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]      gap_limit_ff;
   logic [15:0]      gap_limit_in;
   logic             csr_write;
   logic             req_beat;
   hfr_pkg::rsp_type step_result;
   hfr_pkg::rsp_type out_result;

   // The register file holds a single register; byte address bits [1:0] are ignored
   // and bit 2 selects the register index.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == hfr_pkg::REG_GAP_LIMIT) ? {16'h0000, gap_limit_ff}
                                                                : 32'h0000_0000;

   always_comb begin
      gap_limit_in = gap_limit_ff;
      if (csr_write && (csr_paddr[2] == hfr_pkg::REG_GAP_LIMIT)) begin
         gap_limit_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= hfr_pkg::GAP_LIMIT_RESET;
      end else begin
         gap_limit_ff <= gap_limit_in;
      end
   end

   // The framer state advances exactly on accepted input beats.
   assign req_beat = req_tvalid && req_tready;

   hfr_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_beat),
      .op        (req_tuser),
      .rx_byte   (req_tdata[7:0]),
      .uart_err  (req_tdata[10:8]),
      .tick      (req_tdata[26:11]),
      .gap_limit (gap_limit_ff),
      .result    (step_result)
   );

   // Every accepted beat yields exactly one result beat.
   hfr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {3'b000,
                       out_result.rx_phase,
                       out_result.first_address_byte,
                       out_result.delimiter_byte,
                       out_result.frame_length,
                       out_result.comm_errors,
                       out_result.frame_aborted,
                       out_result.frame_done,
                       out_result.store_byte,
                       out_result.store_index,
                       out_result.store_valid};

   // The buffer only refuses input when it already holds a beat for the output.
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled while no result beat is offered");

   // A release beat always leaves the framer hunting with clean error flags.
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_tuser == hfr_pkg::OP_RELEASE)) |->
      ((step_result.rx_phase == hfr_pkg::PH_HUNT) && (step_result.comm_errors == 5'd0)))
      else $error("release did not return the framer to hunting");

   // A completed frame and an abort never come from the same beat.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |-> !(step_result.frame_done && step_result.frame_aborted))
      else $error("frame reported both done and aborted");

   // A configuration write lands in the gap limit register on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_paddr[2] == hfr_pkg::REG_GAP_LIMIT)) |=>
      (gap_limit_ff == $past(csr_pwdata[15:0])))
      else $error("gap limit write was lost");

endmodule
